// File: design/qtrs_pkg.sv
// ----------------------------------------------------------------------------
// qtrs_pkg
// Shared widths, reset values, register indexes and datapath types for the
// quaternion scale-rotate-translate point transform.
// ----------------------------------------------------------------------------
package qtrs_pkg;

  // Field and port widths
  localparam int COORD_W    = 32;
  localparam int QUAT_W     = 64;
  localparam int LANE_W     = 16;
  localparam int SCALE_W    = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;

  // Internal datapath widths
  localparam int PROD_W  = 2 * LANE_W;           // lane product, Q.28
  localparam int TERM_W  = PROD_W + 2;           // rotation term, Q.28
  localparam int SPROD_W = TERM_W + SCALE_W;     // scaled term, Q.36
  localparam int ELEM_W  = 30;                   // matrix element, Q.16
  localparam int MUL_W   = ELEM_W + COORD_W;     // element times point, Q.32
  localparam int ACC_W   = 64;                   // accumulator, Q.32

  // Rounding shifts
  localparam int SCL_SHIFT = 20;
  localparam int UNS_SHIFT = 12;
  localparam int ACC_SHIFT = 16;
  localparam int SH_W      = ACC_W - ACC_SHIFT;

  // Datapath types
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [LANE_W-1:0]  lane_t;
  typedef logic signed [SCALE_W-1:0] scale_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [TERM_W-1:0]  term_t;
  typedef logic signed [SPROD_W-1:0] sprod_t;
  typedef logic signed [ELEM_W-1:0]  elem_t;
  typedef logic signed [MUL_W-1:0]   mul_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [SH_W-1:0]    sh_t;

  // Fixed-point constants
  localparam term_t  ONE_Q28 = term_t'(1) <<< 28;
  localparam sprod_t SCL_RND = sprod_t'(1) <<< (SCL_SHIFT - 1);
  localparam term_t  UNS_RND = term_t'(1) <<< (UNS_SHIFT - 1);
  localparam acc_t   ACC_RND = acc_t'(1) <<< (ACC_SHIFT - 1);
  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // Register reset values
  localparam logic [QUAT_W-1:0] QUAT_RESET  = 64'h4000_0000_0000_0000;
  localparam scale_t            SCALE_RESET = 16'sd256;
  localparam coord_t            OFFSET_RESET = '0;
  localparam logic              APPLY_RESET  = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUAT    = 8'd0,
    REG_SCALE_X = 8'd1,
    REG_SCALE_Y = 8'd2,
    REG_SCALE_Z = 8'd3,
    REG_OFFSET_X = 8'd4,
    REG_OFFSET_Y = 8'd5,
    REG_OFFSET_Z = 8'd6,
    REG_APPLY   = 8'd7
  } cfg_reg_t;

endpackage

// File: design/qtrs_ifs.sv
// ----------------------------------------------------------------------------
// qtrs channel interfaces
// Point input channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface qtrs_point_if;
  logic            valid;
  logic            ready;
  qtrs_pkg::coord_t point_x;
  qtrs_pkg::coord_t point_y;
  qtrs_pkg::coord_t point_z;

  modport source (output valid, output point_x, output point_y, output point_z,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface

interface qtrs_result_if;
  logic            valid;
  logic            ready;
  qtrs_pkg::coord_t result_x;
  qtrs_pkg::coord_t result_y;
  qtrs_pkg::coord_t result_z;
  logic            overflow;

  modport source (output valid, output result_x, output result_y, output result_z,
                  output overflow, input ready);
  modport sink   (input valid, input result_x, input result_y, input result_z,
                  input overflow, output ready);
endinterface

interface qtrs_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [qtrs_pkg::CFG_IDX_W-1:0]      index;
  logic [qtrs_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/quaternion_trs_point_transform_top.sv
// ----------------------------------------------------------------------------
// quaternion_trs_point_transform_top
// Transforms one Q16.16 point per item by a quaternion rotation, per-axis
// scale and translation, with saturation and an overflow flag.
// ----------------------------------------------------------------------------
// Usage:
//   in_pt   : point items (point_x/y/z, Q16.16), valid/ready.
//   out_res : result items (result_x/y/z, Q16.16 saturated, overflow).
//   cfg_wr  : register writes (index, data); always ready. Index 0 is the
//             packed quaternion, 1-3 scale, 4-6 offset, 7 apply_scaling;
//             other indexes are dropped.
//   Throughput is one item per cycle while out_res.ready is high and the
//   matrix has settled. out_res.valid is registered; the point pipeline
//   stages lie between accept and result: capture, 9 element-by-point
//   multiplies, partial sums, final add with round and saturate.
//   The 3x3 matrix is rebuilt from the registers in a 3-stage side pipeline
//   (lane products, terms, scaled elements); after reset and after every
//   register write in_pt.ready stays low while it settles.
//   Reset (rst_n low, synchronous) restores the register defaults and empties
//   the pipeline. When out_res.ready is low, each stage holds its item until
//   the one ahead frees; nothing is dropped and in_pt.ready falls only once
//   the pipeline is full.
// ----------------------------------------------------------------------------
module quaternion_trs_point_transform_top (
  input  logic             clk,
  input  logic             rst_n,
  qtrs_point_if.sink       in_pt,
  qtrs_result_if.source    out_res,
  qtrs_cfg_if.sink         cfg_wr
);

  // Configuration registers
  logic [qtrs_pkg::QUAT_W-1:0] quat_r;
  qtrs_pkg::scale_t            scale_r [3];
  qtrs_pkg::coord_t            offset_r [3];
  logic                        apply_r;

  // Matrix side pipeline
  qtrs_pkg::lane_t  qw, qx, qy, qz;
  qtrs_pkg::prod_t  xx_r, yy_r, zz_r, xy_r, yz_r, zw_r, wx_r, xz_r, yw_r;
  qtrs_pkg::term_t  term_nxt [3][3];
  qtrs_pkg::term_t  term_r   [3][3];
  qtrs_pkg::sprod_t sprod    [3][3];
  qtrs_pkg::elem_t  elem_nxt [3][3];
  qtrs_pkg::elem_t  elem_r   [3][3];

  // Settle counter after reset or a register write
  logic [1:0] settle_r, settle_nxt;
  logic       cfg_acc;

  // Point pipeline
  logic             rdy_a, rdy_b, rdy_c, rdy_d;
  logic             a_v_r, b_v_r, c_v_r, d_v_r;
  logic             in_acc;
  qtrs_pkg::coord_t a_pt_r  [3];
  qtrs_pkg::mul_t   mul_nxt [3][3];
  qtrs_pkg::mul_t   mul_r   [3][3];
  qtrs_pkg::acc_t   lo_nxt [3], hi_nxt [3];
  qtrs_pkg::acc_t   lo_r   [3], hi_r   [3];
  qtrs_pkg::acc_t   acc    [3];
  qtrs_pkg::sh_t    sh     [3];
  qtrs_pkg::coord_t res_nxt [3];
  qtrs_pkg::coord_t res_r   [3];
  logic [2:0]       clamp;
  logic             ovf_r;

  assign cfg_wr.ready = 1'b1;
  assign cfg_acc      = cfg_wr.valid && cfg_wr.ready;

  // Register file writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_r   <= qtrs_pkg::QUAT_RESET;
      scale_r  <= '{default: qtrs_pkg::SCALE_RESET};
      offset_r <= '{default: qtrs_pkg::OFFSET_RESET};
      apply_r  <= qtrs_pkg::APPLY_RESET;
    end else if (cfg_acc) begin
      unique case (cfg_wr.index)
        qtrs_pkg::REG_QUAT:     quat_r      <= cfg_wr.data;
        qtrs_pkg::REG_SCALE_X:  scale_r[0]  <= cfg_wr.data[qtrs_pkg::SCALE_W-1:0];
        qtrs_pkg::REG_SCALE_Y:  scale_r[1]  <= cfg_wr.data[qtrs_pkg::SCALE_W-1:0];
        qtrs_pkg::REG_SCALE_Z:  scale_r[2]  <= cfg_wr.data[qtrs_pkg::SCALE_W-1:0];
        qtrs_pkg::REG_OFFSET_X: offset_r[0] <= cfg_wr.data[qtrs_pkg::COORD_W-1:0];
        qtrs_pkg::REG_OFFSET_Y: offset_r[1] <= cfg_wr.data[qtrs_pkg::COORD_W-1:0];
        qtrs_pkg::REG_OFFSET_Z: offset_r[2] <= cfg_wr.data[qtrs_pkg::COORD_W-1:0];
        qtrs_pkg::REG_APPLY:    apply_r     <= cfg_wr.data[0];
        default: ;
      endcase
    end
  end

  // Hold the point input off until the matrix reflects the registers
  always_comb begin
    if (cfg_acc) begin
      settle_nxt = 2'd3;
    end else if (settle_r != 2'd0) begin
      settle_nxt = settle_r - 2'd1;
    end else begin
      settle_nxt = settle_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= 2'd3;
    end else begin
      settle_r <= settle_nxt;
    end
  end

  // Matrix stage 1: quaternion lane products
  assign qw = quat_r[63:48];
  assign qx = quat_r[47:32];
  assign qy = quat_r[31:16];
  assign qz = quat_r[15:0];

  always_ff @(posedge clk) begin
    xx_r <= qx * qx;
    yy_r <= qy * qy;
    zz_r <= qz * qz;
    xy_r <= qx * qy;
    yz_r <= qy * qz;
    zw_r <= qz * qw;
    wx_r <= qw * qx;
    xz_r <= qx * qz;
    yw_r <= qy * qw;
  end

  // Matrix stage 2: rotation terms, indexed [column][row]
  always_comb begin
    term_nxt[0][0] = qtrs_pkg::ONE_Q28
                   - ((qtrs_pkg::term_t'(yy_r) + qtrs_pkg::term_t'(zz_r)) <<< 1);
    term_nxt[0][1] = (qtrs_pkg::term_t'(xy_r) + qtrs_pkg::term_t'(zw_r)) <<< 1;
    term_nxt[0][2] = (qtrs_pkg::term_t'(xz_r) - qtrs_pkg::term_t'(yw_r)) <<< 1;
    term_nxt[1][0] = (qtrs_pkg::term_t'(xy_r) - qtrs_pkg::term_t'(zw_r)) <<< 1;
    term_nxt[1][1] = qtrs_pkg::ONE_Q28
                   - ((qtrs_pkg::term_t'(xx_r) + qtrs_pkg::term_t'(zz_r)) <<< 1);
    term_nxt[1][2] = (qtrs_pkg::term_t'(yz_r) + qtrs_pkg::term_t'(wx_r)) <<< 1;
    term_nxt[2][0] = (qtrs_pkg::term_t'(xz_r) + qtrs_pkg::term_t'(yw_r)) <<< 1;
    term_nxt[2][1] = (qtrs_pkg::term_t'(yz_r) - qtrs_pkg::term_t'(wx_r)) <<< 1;
    term_nxt[2][2] = qtrs_pkg::ONE_Q28
                   - ((qtrs_pkg::term_t'(xx_r) + qtrs_pkg::term_t'(yy_r)) <<< 1);
  end

  always_ff @(posedge clk) begin
    term_r <= term_nxt;
  end

  // Matrix stage 3: scale each column (when apply_r is set) and round to Q.16
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        sprod[c][r] = qtrs_pkg::sprod_t'(term_r[c][r]) * qtrs_pkg::sprod_t'(scale_r[c]);
        if (apply_r) begin
          elem_nxt[c][r] = qtrs_pkg::elem_t'((sprod[c][r] + qtrs_pkg::SCL_RND)
                                             >>> qtrs_pkg::SCL_SHIFT);
        end else begin
          elem_nxt[c][r] = qtrs_pkg::elem_t'((term_r[c][r] + qtrs_pkg::UNS_RND)
                                             >>> qtrs_pkg::UNS_SHIFT);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
  end

  // Point pipeline flow control: a stage advances when empty or drained
  assign rdy_d       = !d_v_r || out_res.ready;
  assign rdy_c       = !c_v_r || rdy_d;
  assign rdy_b       = !b_v_r || rdy_c;
  assign rdy_a       = !a_v_r || rdy_b;
  assign in_pt.ready = rdy_a && (settle_r == 2'd0);
  assign in_acc      = in_pt.valid && in_pt.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else begin
      if (rdy_a) begin
        a_v_r <= in_acc;
      end
      if (rdy_b) begin
        b_v_r <= a_v_r;
      end
      if (rdy_c) begin
        c_v_r <= b_v_r;
      end
      if (rdy_d) begin
        d_v_r <= c_v_r;
      end
    end
  end

  // Stage A: capture the point
  always_ff @(posedge clk) begin
    if (rdy_a) begin
      a_pt_r[0] <= in_pt.point_x;
      a_pt_r[1] <= in_pt.point_y;
      a_pt_r[2] <= in_pt.point_z;
    end
  end

  // Stage B: element times point coordinate
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        mul_nxt[c][r] = qtrs_pkg::mul_t'(elem_r[c][r]) * qtrs_pkg::mul_t'(a_pt_r[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      mul_r <= mul_nxt;
    end
  end

  // Stage C: partial sums, offset and rounding bias folded in
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      lo_nxt[r] = qtrs_pkg::acc_t'(mul_r[0][r]) + qtrs_pkg::acc_t'(mul_r[1][r]);
      hi_nxt[r] = qtrs_pkg::acc_t'(mul_r[2][r])
                + (qtrs_pkg::acc_t'(offset_r[r]) <<< qtrs_pkg::ACC_SHIFT)
                + qtrs_pkg::ACC_RND;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

  // Stage D: final add, drop fraction, saturate
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = lo_r[r] + hi_r[r];
      sh[r]  = acc[r][qtrs_pkg::ACC_W-1:qtrs_pkg::ACC_SHIFT];
      if ((&sh[r][qtrs_pkg::SH_W-1:qtrs_pkg::COORD_W-1])
          || !(|sh[r][qtrs_pkg::SH_W-1:qtrs_pkg::COORD_W-1])) begin
        clamp[r]   = 1'b0;
        res_nxt[r] = sh[r][qtrs_pkg::COORD_W-1:0];
      end else begin
        clamp[r]   = 1'b1;
        res_nxt[r] = sh[r][qtrs_pkg::SH_W-1] ? qtrs_pkg::COORD_MIN : qtrs_pkg::COORD_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_d) begin
      res_r <= res_nxt;
      ovf_r <= |clamp;
    end
  end

  assign out_res.valid    = d_v_r;
  assign out_res.result_x = res_r[0];
  assign out_res.result_y = res_r[1];
  assign out_res.result_z = res_r[2];
  assign out_res.overflow = ovf_r;

endmodule

// File: design/qtrs_checker.sv
// ----------------------------------------------------------------------------
// qtrs_checker
// Port-level checks for the point transform: reset, latency, settling after
// register writes, saturation flag and output hold under stall.
// ----------------------------------------------------------------------------
module qtrs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [31:0]  result_x,
  input logic signed [31:0]  result_y,
  input logic signed [31:0]  result_z,
  input logic                overflow,
  input logic                cfg_valid,
  input logic                cfg_ready
);

  localparam logic signed [31:0] RES_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] RES_MIN = 32'sh8000_0000;

  // Reset empties the output stage
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A rising result valid must match an item taken at the input
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 4))
    else $error("result without matching input four cycles earlier");

  // Input is held off right after a register write
  a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> !in_ready)
    else $error("input ready right after register write");

  // Overflow means some coordinate sits at a limit
  a_ovf_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && overflow) |->
      (result_x == RES_MAX || result_x == RES_MIN || result_y == RES_MAX ||
       result_y == RES_MIN || result_z == RES_MAX || result_z == RES_MIN))
    else $error("overflow set with no clamped coordinate");

  // Stalled result stays put
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(result_x) && $stable(result_y) && $stable(result_z)
       && $stable(overflow)))
    else $error("stalled result changed");

endmodule

bind quaternion_trs_point_transform_top qtrs_checker u_qtrs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_pt.valid),
  .in_ready  (in_pt.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .result_x  (out_res.result_x),
  .result_y  (out_res.result_y),
  .result_z  (out_res.result_z),
  .overflow  (out_res.overflow),
  .cfg_valid (cfg_wr.valid),
  .cfg_ready (cfg_wr.ready)
);
